@@ sv/abws_pkg.sv @@
// Shared constants for the accessed-bit working-set sampler.
`timescale 1ns / 1ps
`default_nettype none
package abws_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 18;
  localparam int PIDX_W   = 17;
  localparam int COUNT_W  = 18;
  localparam int EST_W    = 31;

  // Bitmap row geometry: 16 accessed bits per RAM word
  localparam int ROW_BITS = 16;
  localparam int BSEL_W   = 4;

  // Saturation limits and register reset
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 18'h3FFFF;
  localparam logic [EST_W-1:0]    EST_MAX      = 31'h7FFFFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 18'd1000;

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

endpackage
`default_nettype wire

@@ sv/abws_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module abws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/abws_div.sv @@
// Restoring divider, one quotient bit per cycle, divisor of sample-size width.
`timescale 1ns / 1ps
`default_nettype none
module abws_div
  import abws_pkg::*;
#(
  parameter int DVD_W = 36
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [SAMPLE_W-1:0] divisor,
  output logic                     done,
  output logic      [DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] dsr;
  logic [CNT_W-1:0]    cnt;
  logic                run;
  logic [SAMPLE_W:0]   rem_sh;
  logic [SAMPLE_W:0]   diff;
  logic                ge;

  // one restoring step
  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath: the dividend register shifts out and collects quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (run) begin
      quotient <= {quotient[DVD_W-2:0], ge};
      rem      <= ge ? diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ sv/accessed_bit_working_set_sampler_unit.sv @@
// Top level of the accessed-bit working-set sampler: bitmap RAM, walker, estimate math.
//
// Input words are accepted on a rising edge with start high and busy low.
// operation 0 sets the accessed bit of page_index (ignored when out of range) and
// gives no result; busy stays low, so access words can follow every cycle. The bit
// is set by a two-stage read-modify-write of a 16-bit bitmap row with forwarding.
// operation 1 samples the bitmap: pages 0, s, 2s, ... are tested and cleared, with
// s = PAGE_COUNT / sample_pages clamped to at least 1 (a size of 0 acts as 1).
// The result word (accessed_count, estimate_bytes) is registered and held until the
// next sample word, marked by done for one cycle; the receiver cannot stall it.
// A sample word keeps busy high while the walker visits the pages (one per cycle)
// and the shared divider runs its two bit-serial divides (stride, then estimate);
// done is high in the cycle busy drops.
// sample_pages is written through cfg_we / cfg_data; the user is to write it only
// while the block is idle, which the block itself does not enforce.
// Reset: rst clears control and sets sample_pages to 1000; the bitmap RAM is then
// cleared one row per cycle, with busy high. Configuration writes are taken during
// that pass.
`timescale 1ns / 1ps
`default_nettype none
module accessed_bit_working_set_sampler_unit
  import abws_pkg::*;
#(
  parameter int PAGE_COUNT = 131072,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation,
  input  wire logic [PIDX_W-1:0]   page_index,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_data,
  output logic                     done,
  output logic      [COUNT_W-1:0]  accessed_count,
  output logic      [EST_W-1:0]    estimate_bytes
);

  // derived sizes
  localparam int PAGE_W = $clog2(PAGE_COUNT + 1);
  localparam int IDX_W  = $clog2(2 * PAGE_COUNT);
  localparam int CMP_W  = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;
  localparam int ROWS   = (PAGE_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DVD_W  = 2 * PAGE_W;
  localparam int Q_W    = (DVD_W > EST_W) ? DVD_W : EST_W;
  localparam int PS_W   = $clog2(PAGE_BYTES + 1);
  localparam int EP_W   = EST_W + PS_W;
  localparam int C_W    = (PAGE_W > COUNT_W) ? PAGE_W : COUNT_W;

  // state codes
  localparam logic [3:0] ST_CLEAR       = 4'd0;
  localparam logic [3:0] ST_IDLE        = 4'd1;
  localparam logic [3:0] ST_STRIDE_GO   = 4'd2;
  localparam logic [3:0] ST_STRIDE_WAIT = 4'd3;
  localparam logic [3:0] ST_WALK        = 4'd4;
  localparam logic [3:0] ST_DRAIN       = 4'd5;
  localparam logic [3:0] ST_MUL         = 4'd6;
  localparam logic [3:0] ST_EST_GO      = 4'd7;
  localparam logic [3:0] ST_EST_WAIT    = 4'd8;
  localparam logic [3:0] ST_SCALE       = 4'd9;
  localparam logic [3:0] ST_EMIT        = 4'd10;

  logic [3:0]          state;
  logic [SAMPLE_W-1:0] sample_pages;
  logic [SAMPLE_W-1:0] divisor;
  logic [ROW_W-1:0]    clr_row;
  logic [IDX_W-1:0]    walk_idx;
  logic [IDX_W-1:0]    stride;
  logic [PAGE_W-1:0]   count;
  logic [DVD_W-1:0]    prod;
  logic                est_sat;
  logic [EST_W-1:0]    est_q;
  logic [EP_W-1:0]     est_prod;

  // read-modify-write pipeline
  logic                req_valid;
  logic                req_clr;
  logic [ROW_W-1:0]    req_row;
  logic [BSEL_W-1:0]   req_bsel;
  logic                s1_valid;
  logic                s1_clr;
  logic [ROW_W-1:0]    s1_row;
  logic [BSEL_W-1:0]   s1_bsel;
  logic                wr_valid;
  logic [ROW_W-1:0]    wr_row;
  logic [ROW_BITS-1:0] wr_data;
  logic [ROW_BITS-1:0] rdata;
  logic [ROW_BITS-1:0] cur_row;
  logic [ROW_BITS-1:0] mask;
  logic [ROW_BITS-1:0] new_row;
  logic                hit;

  // RAM port signals
  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;

  // divider signals
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic                div_done;
  logic [DVD_W-1:0]    div_q;
  logic [Q_W-1:0]      q_ext;

  logic [CMP_W-1:0]    pg_ext;
  logic                accept;
  logic                walk_more;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign pg_ext    = CMP_W'(page_index);
  assign walk_more = walk_idx < IDX_W'(PAGE_COUNT);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_pages <= SAMPLE_RESET;
    end else if (cfg_we) begin
      sample_pages <= cfg_data;
    end
  end

  // bitmap request: access set or walker test-and-clear
  always_comb begin
    req_valid = 1'b0;
    req_clr   = 1'b0;
    req_row   = pg_ext[ROW_W+BSEL_W-1:BSEL_W];
    req_bsel  = pg_ext[BSEL_W-1:0];
    if (state == ST_WALK) begin
      req_valid = walk_more;
      req_clr   = 1'b1;
      req_row   = walk_idx[ROW_W+BSEL_W-1:BSEL_W];
      req_bsel  = walk_idx[BSEL_W-1:0];
    end else if (accept && operation == OP_ACCESS) begin
      req_valid = pg_ext < CMP_W'(PAGE_COUNT);
    end
  end

  // second stage: merge, forwarding the write of the previous cycle
  assign hit     = wr_valid && (wr_row == s1_row);
  assign cur_row = hit ? wr_data : rdata;
  assign mask    = ROW_BITS'(1) << s1_bsel;
  assign new_row = s1_clr ? (cur_row & ~mask) : (cur_row | mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= req_valid;
      wr_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_clr  <= req_clr;
    s1_row  <= req_row;
    s1_bsel <= req_bsel;
    wr_row  <= s1_row;
    wr_data <= new_row;
  end

  // write port: clearing pass after reset, otherwise pipeline write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid;
      ram_waddr = s1_row;
      ram_wdata = new_row;
    end
  end

  abws_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (req_row),
    .rdata (rdata)
  );

  // shared divider: stride first, then the estimate
  assign div_start    = (state == ST_STRIDE_GO) || (state == ST_EST_GO);
  assign div_dividend = (state == ST_STRIDE_GO) ? DVD_W'(PAGE_COUNT) : prod;
  assign q_ext        = Q_W'(div_q);

  abws_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && operation == OP_SAMPLE) begin
            state <= ST_STRIDE_GO;
          end
        end
        ST_STRIDE_GO: state <= ST_STRIDE_WAIT;
        ST_STRIDE_WAIT: begin
          if (div_done) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!walk_more) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:    state <= ST_EST_GO;
        ST_EST_GO: state <= ST_EST_WAIT;
        ST_EST_WAIT: begin
          if (div_done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_EMIT;
        ST_EMIT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && operation == OP_SAMPLE) begin
      divisor <= (sample_pages == '0) ? SAMPLE_W'(1) : sample_pages;
    end
    if (state == ST_STRIDE_WAIT && div_done) begin
      stride   <= (div_q == '0) ? IDX_W'(1) : div_q[IDX_W-1:0];
      walk_idx <= '0;
      count    <= '0;
    end
    if (state == ST_WALK && walk_more) begin
      walk_idx <= walk_idx + stride;
    end
    // count set bits as the test-and-clear words come back
    if (s1_valid && s1_clr && ((cur_row & mask) != '0)) begin
      count <= count + 1'b1;
    end
    if (state == ST_MUL) begin
      prod <= DVD_W'(count) * DVD_W'(PAGE_COUNT);
    end
    if (state == ST_EST_WAIT && div_done) begin
      est_sat <= q_ext > Q_W'(EST_MAX);
      est_q   <= q_ext[EST_W-1:0];
    end
    if (state == ST_SCALE) begin
      est_prod <= EP_W'(est_q) * EP_W'(PAGE_BYTES);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      accessed_count <= (C_W'(count) > C_W'(COUNT_MAX)) ? COUNT_MAX : count[COUNT_W-1:0];
      estimate_bytes <= (est_sat || est_prod > EP_W'(EST_MAX)) ? EST_MAX
                                                               : est_prod[EST_W-1:0];
    end
  end

  // checks
  a_clear_no_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s1_valid)
    else $error("bitmap write-back during clearing pass");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EMIT))
    else $error("result strobe without emit state");

  a_stride_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (stride != '0))
    else $error("walk with zero stride");

endmodule
`default_nettype wire
